>>> rtl/wra_pkg.sv
// Shared types and constants for the waiting request arbiter.
// No dependencies; every other file of the block refers to this package.
package wra_pkg;

  // Default table geometry, handed down through the top-level parameters.
  localparam int DefTableEntries = 16;
  localparam int DefRankCount    = 256;
  localparam int DefStampBits    = 32;

  // Fixed widths of the request and response fields.
  localparam int RankW    = 8;
  localparam int StampInW = 32;

  // Request operation codes.
  typedef enum logic [0:0] {
    OpArrive = 1'b0,
    OpPoll   = 1'b1
  } op_e;

  // Table access controls, one operation per cycle on the shared address.
  typedef struct packed {
    logic rd_en;   // read rank, stamp and valid bit, data next cycle
    logic wr_en;   // write rank and stamp, mark entry valid
    logic clr_en;  // mark entry free
  } tbl_ctrl_t;

endpackage

>>> rtl/wra_req_if.sv
// Request channel of the waiting request arbiter: valid/ready plus payload.
// Depends on wra_pkg for field widths.
interface wra_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [wra_pkg::RankW-1:0]    requester_rank;
  logic [wra_pkg::StampInW-1:0] stamp;
  logic                       waiting_valid;
  logic [wra_pkg::RankW-1:0]    waiting_rank;

  modport source (
    output valid, operation, requester_rank, stamp, waiting_valid, waiting_rank,
    input  ready
  );
  modport sink (
    input  valid, operation, requester_rank, stamp, waiting_valid, waiting_rank,
    output ready
  );
endinterface

>>> rtl/wra_rsp_if.sv
// Response channel of the waiting request arbiter: valid/ready plus result.
// Depends on wra_pkg for field widths.
interface wra_rsp_if;
  logic                    valid;
  logic                    ready;
  logic                    grant_valid;
  logic [wra_pkg::RankW-1:0] grant_rank;
  logic                    dropped;

  modport source (
    output valid, grant_valid, grant_rank, dropped,
    input  ready
  );
  modport sink (
    input  valid, grant_valid, grant_rank, dropped,
    output ready
  );
endinterface

>>> rtl/wra_table.sv
// Pending request table: rank/stamp memory with registered read, plus valid bits.
// Depends on wra_pkg for the control struct and rank width.
module wra_table #(
  parameter int Entries = wra_pkg::DefTableEntries,
  parameter int StampW  = wra_pkg::StampInW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wra_pkg::tbl_ctrl_t            ctrl_i,
  input  logic [$clog2(Entries)-1:0]    addr_i,
  input  logic [wra_pkg::RankW-1:0]     wr_rank_i,
  input  logic [StampW-1:0]             wr_stamp_i,
  output logic                          cur_valid_o,
  output logic                          rd_valid_o,
  output logic [wra_pkg::RankW-1:0]     rd_rank_o,
  output logic [StampW-1:0]             rd_stamp_o
);

  localparam int WordW = wra_pkg::RankW + StampW;

  logic [WordW-1:0]   mem_q [Entries];
  logic [WordW-1:0]   rd_word_q;
  logic               rd_valid_q;
  logic [Entries-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[addr_i] <= {wr_rank_i, wr_stamp_i};
    end
    if (ctrl_i.rd_en) begin
      rd_word_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q[addr_i] <= 1'b1;
      end else if (ctrl_i.clr_en) begin
        valid_q[addr_i] <= 1'b0;
      end
      if (ctrl_i.rd_en) begin
        rd_valid_q <= valid_q[addr_i];
      end
    end
  end

  assign cur_valid_o = valid_q[addr_i];
  assign rd_valid_o  = rd_valid_q;
  assign rd_rank_o   = rd_word_q[WordW-1:StampW];
  assign rd_stamp_o  = rd_word_q[StampW-1:0];

endmodule

>>> rtl/waiting_request_arbiter_core.sv
// Waiting request arbiter: table of pending peer requests with wait-aware grants.
// Depends on wra_pkg, wra_req_if, wra_rsp_if and wra_table.
//
// Usage:
//   req_i carries one request per valid/ready handshake. An arrive request
//   (operation = arrive) stores a requester rank and stamp in the lowest free
//   slot; a poll request grants and removes at most one pending entry, chosen by age
//   and by the rank the caller waits for. rsp_o returns exactly one response
//   per request, in order.
//   Sequence: a poll walks the whole table through the memory read port, one
//   entry per cycle in StScan, then goes through StDrain to StFinish, where
//   its response is registered once the output register is free, and the
//   block returns to StIdle for the next request. An arrive walks the valid
//   bits to the first free slot; a refused rank goes straight to StFinish.
//   One request is in flight at a time; the single memory port and the table
//   walk set the rate. Reset clears all valid bits at once, so the table
//   starts empty with no clearing pass; the block is ready for a request as
//   soon as reset is released. A response waits in the output register while
//   rsp_o stalls; the next request is still accepted, and its response holds
//   until the register drains.
module waiting_request_arbiter_core #(
  parameter int TABLE_ENTRIES = wra_pkg::DefTableEntries,
  parameter int RANK_COUNT    = wra_pkg::DefRankCount,
  parameter int STAMP_BITS    = wra_pkg::DefStampBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wra_req_if.sink   req_i,
  wra_rsp_if.source rsp_o
);

  localparam int IdxW   = $clog2(TABLE_ENTRIES);
  // Stamps are compared on their low min(STAMP_BITS, 32) bits; the field has 32.
  localparam int StampW = (STAMP_BITS < wra_pkg::StampInW) ? STAMP_BITS
                                                          : wra_pkg::StampInW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    StIdle,
    StArrive,
    StScan,
    StDrain,
    StFinish
  } state_e;

  state_e                    state_q;
  logic [IdxW-1:0]           idx_q;
  wra_pkg::op_e              op_q;
  logic [wra_pkg::RankW-1:0] rank_q;
  logic [StampW-1:0]         stamp_q;
  logic                      wvalid_q;
  logic [wra_pkg::RankW-1:0] wrank_q;
  logic                      drop_q;

  // Read pipeline bookkeeping: data for rd_idx_q shows up this cycle.
  logic                      rd_act_q;
  logic [IdxW-1:0]           rd_idx_q;

  // Candidate a: exact wait match (or any entry when not waiting).
  // Candidate b: oldest entry ranked below the awaited peer.
  logic                      a_found_q, b_found_q;
  logic [IdxW-1:0]           a_slot_q, b_slot_q;
  logic [StampW-1:0]         a_stamp_q, b_stamp_q;
  logic [wra_pkg::RankW-1:0] a_rank_q, b_rank_q;

  logic                      out_valid_q;
  logic                      out_gv_q;
  logic [wra_pkg::RankW-1:0] out_rank_q;
  logic                      out_drop_q;

  wra_pkg::tbl_ctrl_t        tbl_ctrl;
  logic [IdxW-1:0]           tbl_addr;
  logic                      cur_valid;
  logic                      rd_valid;
  logic [wra_pkg::RankW-1:0] rd_rank;
  logic [StampW-1:0]         rd_stamp;

  logic                      accept;
  logic                      rank_ok;
  logic                      fire;
  logic                      hit_a, hit_b;
  logic                      grant;
  logic [IdxW-1:0]           grant_slot;
  logic [wra_pkg::RankW-1:0] grant_rank;

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign rank_ok     = (32'(req_i.requester_rank) < RANK_COUNT);

  // The output register must be free (or draining) to take a result.
  assign fire = (state_q == StFinish) && (!out_valid_q || rsp_o.ready);

  // Scan compare: strict less-than keeps the lowest slot on equal stamps.
  assign hit_a = rd_act_q && rd_valid && (!wvalid_q || (rd_rank == wrank_q)) &&
                 (!a_found_q || (rd_stamp < a_stamp_q));
  assign hit_b = rd_act_q && rd_valid && wvalid_q && (rd_rank < wrank_q) &&
                 (!b_found_q || (rd_stamp < b_stamp_q));

  // Prefer the exact match; fall back to the lower-rank pick.
  assign grant      = a_found_q || b_found_q;
  assign grant_slot = a_found_q ? a_slot_q : b_slot_q;
  assign grant_rank = a_found_q ? a_rank_q : b_rank_q;

  always_comb begin
    tbl_ctrl        = '0;
    tbl_ctrl.rd_en  = (state_q == StScan);
    tbl_ctrl.wr_en  = (state_q == StArrive) && !cur_valid;
    tbl_ctrl.clr_en = fire && (op_q == wra_pkg::OpPoll) && grant;
    tbl_addr        = (state_q == StFinish) ? grant_slot : idx_q;
  end

  wra_table #(
    .Entries (TABLE_ENTRIES),
    .StampW  (StampW)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (tbl_ctrl),
    .addr_i      (tbl_addr),
    .wr_rank_i   (rank_q),
    .wr_stamp_i  (stamp_q),
    .cur_valid_o (cur_valid),
    .rd_valid_o  (rd_valid),
    .rd_rank_o   (rd_rank),
    .rd_stamp_o  (rd_stamp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      op_q        <= wra_pkg::OpArrive;
      rank_q      <= '0;
      stamp_q     <= '0;
      wvalid_q    <= 1'b0;
      wrank_q     <= '0;
      drop_q      <= 1'b0;
      rd_act_q    <= 1'b0;
      rd_idx_q    <= '0;
      a_found_q   <= 1'b0;
      b_found_q   <= 1'b0;
      a_slot_q    <= '0;
      b_slot_q    <= '0;
      a_stamp_q   <= '0;
      b_stamp_q   <= '0;
      a_rank_q    <= '0;
      b_rank_q    <= '0;
      out_valid_q <= 1'b0;
      out_gv_q    <= 1'b0;
      out_rank_q  <= '0;
      out_drop_q  <= 1'b0;
    end else begin
      // Track which entry the memory is returning.
      rd_act_q <= (state_q == StScan);
      rd_idx_q <= idx_q;

      // Fold each returned entry into both candidates.
      if (hit_a) begin
        a_found_q <= 1'b1;
        a_slot_q  <= rd_idx_q;
        a_stamp_q <= rd_stamp;
        a_rank_q  <= rd_rank;
      end
      if (hit_b) begin
        b_found_q <= 1'b1;
        b_slot_q  <= rd_idx_q;
        b_stamp_q <= rd_stamp;
        b_rank_q  <= rd_rank;
      end

      unique case (state_q)
        StIdle: begin
          if (accept) begin
            op_q      <= wra_pkg::op_e'(req_i.operation);
            rank_q    <= req_i.requester_rank;
            stamp_q   <= req_i.stamp[StampW-1:0];
            wvalid_q  <= req_i.waiting_valid;
            wrank_q   <= req_i.waiting_rank;
            drop_q    <= 1'b0;
            idx_q     <= '0;
            a_found_q <= 1'b0;
            b_found_q <= 1'b0;
            if (wra_pkg::op_e'(req_i.operation) == wra_pkg::OpPoll) begin
              state_q <= StScan;
            end else if (!rank_ok) begin
              // Refuse out-of-range ranks like a full table.
              drop_q  <= 1'b1;
              state_q <= StFinish;
            end else begin
              state_q <= StArrive;
            end
          end
        end
        StArrive: begin
          // Stop at the first free slot; the write happens this cycle.
          if (!cur_valid) begin
            state_q <= StFinish;
          end else if (idx_q == LastIdx) begin
            drop_q  <= 1'b1;
            state_q <= StFinish;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        StScan: begin
          if (idx_q == LastIdx) begin
            state_q <= StDrain;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        StDrain: begin
          // Last read data is folded in at this edge.
          state_q <= StFinish;
        end
        StFinish: begin
          if (fire) begin
            out_gv_q   <= (op_q == wra_pkg::OpPoll) && grant;
            out_rank_q <= ((op_q == wra_pkg::OpPoll) && grant) ? grant_rank : '0;
            out_drop_q <= (op_q == wra_pkg::OpArrive) && drop_q;
            state_q    <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase

      // Hold the response until the receiver takes it.
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.grant_valid = out_gv_q;
  assign rsp_o.grant_rank  = out_rank_q;
  assign rsp_o.dropped     = out_drop_q;

endmodule
